[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker of the normal accumulator.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/mvna_pkg.sv]
// Shared constants and types of the mesh vertex normal accumulator.
// No dependencies.
package mvna_pkg;

  localparam int unsigned VERTEX_COUNT_DEF = 1024;
  localparam int unsigned MAX_CORNERS      = 4;
  localparam int unsigned CORNER_LIMIT     = (MAX_CORNERS < 4) ? MAX_CORNERS : 4;
  localparam int unsigned POS_W            = 32;
  localparam int unsigned VEC_W            = 3 * POS_W;

  typedef enum logic [1:0] {
    OP_WRITE_POS   = 2'd0,
    OP_ADD_FACE    = 2'd1,
    OP_READ_NORMAL = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

endpackage

[rtl/mesh_vertex_normal_accumulator_core.sv]
// Mesh vertex normal accumulator: position store, normal store, face normal unit.
// Depends on mvna_pkg and mvna_ram.
//
//   channel | handshake             | fields
//   in      | in_valid_i/in_stall_o  | operation, vertex_index, coord_x/y/z, corners
//   out     | out_valid_o/out_stall_i| out_normal_x/y/z, status
//
// One word at a time. The time for a face is set by the bit-serial square root and the
// divider lanes; a degenerate face ends early. After reset the normal store is swept to
// zero with in_stall_o high. A finished result waits in the output register under
// out_stall_i; the next word is taken meanwhile.
module mesh_vertex_normal_accumulator_core
  import mvna_pkg::*;
#(
  parameter int unsigned VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [9:0]         vertex_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [2:0]         corner_count_i,
  input  logic [9:0]         corner_a_i,
  input  logic [9:0]         corner_b_i,
  input  logic [9:0]         corner_c_i,
  input  logic [9:0]         corner_d_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_normal_x_o,
  output logic signed [31:0] out_normal_y_o,
  output logic signed [31:0] out_normal_z_o,
  output logic               status_o
);

  localparam int unsigned AW = $clog2(VERTEX_COUNT);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CLEAR = 16'h0002,
    S_PWR   = 16'h0004,
    S_RRD   = 16'h0008,
    S_RCAP  = 16'h0010,
    S_PRD   = 16'h0020,
    S_MUL   = 16'h0040,
    S_ABS   = 16'h0080,
    S_NORM  = 16'h0100,
    S_SQR   = 16'h0200,
    S_SQRT  = 16'h0400,
    S_DIV   = 16'h0800,
    S_RES   = 16'h1000,
    S_NRD   = 16'h2000,
    S_NWR   = 16'h4000,
    S_DONE  = 16'h8000
  } state_e;

  function automatic logic [AW-1:0] reduce_idx(input logic [9:0] v);
    logic [16:0] r;
    r = '0;
    for (int i = 9; i >= 0; i--) begin
      r = {r[15:0], v[i]};
      if (r >= 17'(VERTEX_COUNT)) begin
        r = r - 17'(VERTEX_COUNT);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic signed [32:0] sub33(input logic [31:0] b, input logic [31:0] a);
    return $signed({b[31], b}) - $signed({a[31], a});
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [31:0] v);
    logic [32:0] t;
    t = {s[31], s} + {v[31], v};
    if (t[32] != t[31]) begin
      return t[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return t[31:0];
  endfunction

  state_e state_q, state_d;
  logic [4:0]    step_q, step_d;
  logic [AW-1:0] clr_q;
  logic          out_valid_q;

  logic [AW-1:0]    idx_q;
  logic [AW-1:0]    corner_q [4];
  logic [2:0]       cnt_q;
  logic [VEC_W-1:0] coord_q;
  logic [VEC_W-1:0] pa_q;
  logic signed [32:0] e1_q [3];
  logic signed [32:0] e2_q [3];
  logic signed [65:0] prod_q, first_q;
  logic signed [66:0] cross_q [3];
  logic [65:0]   mag_q [3];
  logic          neg_q [3];
  logic [62:0]   sq_s_q, sq_r_q, sq_bit_q;
  logic [31:0]   rem_q [3];
  logic [16:0]   numlo_q [3];
  logic [16:0]   quo_q [3];
  logic [31:0]   res_q [3];
  logic          status_q;
  logic [31:0]   out_x_q, out_y_q, out_z_q;
  logic          out_status_q;

  logic accept, out_free;
  logic [AW-1:0]    corner_sel;
  logic [VEC_W-1:0] pos_rdata, nrm_rdata, nrm_wdata;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [65:0]   or_w;
  logic [6:0]    nsh;
  logic [62:0]   sq_t;
  logic [30:0]   len_w;
  logic [2:0]    cnt_in;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign corner_sel = corner_q[step_q[1:0]];
  assign or_w       = mag_q[0] | mag_q[1] | mag_q[2];
  assign nsh        = 7'(7'd64 >> step_q[2:0]);
  assign sq_t       = sq_r_q + sq_bit_q;
  assign len_w      = sq_r_q[30:0];

  always_comb begin
    if (corner_count_i < 3'd3) begin
      cnt_in = 3'd3;
    end else if (corner_count_i > 3'(CORNER_LIMIT)) begin
      cnt_in = 3'(CORNER_LIMIT);
    end else begin
      cnt_in = corner_count_i;
    end
  end

  // Shared multiplier: cross product terms, then the squares of the scaled terms.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_MUL) begin
      unique case (step_q[2:0])
        3'd0: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
        3'd1: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
        3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
        3'd3: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
        3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
        3'd5: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == S_SQR && step_q < 5'd3) begin
      mul_a = $signed({3'b000, mag_q[step_q[1:0]][65:36]});
      mul_b = mul_a;
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nrm_wdata[VEC_W-1-32*k -: 32] = sat_add(nrm_rdata[VEC_W-1-32*k -: 32], res_q[k]);
    end
  end

  mvna_ram #(.Width(VEC_W), .Depth(VERTEX_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_PWR),
    .waddr_i (idx_q),
    .wdata_i (coord_q),
    .re_i    (state_q == S_PRD && step_q < 5'd3),
    .raddr_i (corner_sel),
    .rdata_o (pos_rdata)
  );

  mvna_ram #(.Width(VEC_W), .Depth(VERTEX_COUNT)) u_nrm_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_CLEAR || state_q == S_NWR),
    .waddr_i ((state_q == S_CLEAR) ? clr_q : corner_sel),
    .wdata_i ((state_q == S_CLEAR) ? '0 : nrm_wdata),
    .re_i    (state_q == S_RRD || state_q == S_NRD),
    .raddr_i ((state_q == S_RRD) ? idx_q : corner_sel),
    .rdata_o (nrm_rdata)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == AW'(VERTEX_COUNT - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          step_d = '0;
          unique case (op_e'(operation_i))
            OP_WRITE_POS:   state_d = S_PWR;
            OP_ADD_FACE:    state_d = S_PRD;
            OP_READ_NORMAL: state_d = S_RRD;
            OP_NONE:        state_d = S_DONE;
          endcase
        end
      end
      S_PWR:  state_d = S_DONE;
      S_RRD:  state_d = S_RCAP;
      S_RCAP: state_d = S_DONE;
      S_PRD: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd3) begin
          state_d = S_MUL;
          step_d  = '0;
        end
      end
      S_MUL: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd6) state_d = S_ABS;
      end
      S_ABS: begin
        state_d = S_NORM;
        step_d  = '0;
      end
      S_NORM: begin
        step_d = step_q + 5'd1;
        if (or_w == '0) begin
          state_d = S_DONE;
        end else if (step_q == 5'd6) begin
          state_d = S_SQR;
          step_d  = '0;
        end
      end
      S_SQR: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd3) state_d = S_SQRT;
      end
      S_SQRT: begin
        if (sq_bit_q == '0) begin
          state_d = S_DIV;
          step_d  = '0;
        end
      end
      S_DIV: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd16) state_d = S_RES;
      end
      S_RES: begin
        state_d = S_NRD;
        step_d  = '0;
      end
      S_NRD: state_d = S_NWR;
      S_NWR: begin
        if ((step_q[2:0] + 3'd1) == cnt_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_NRD;
          step_d  = step_q + 5'd1;
        end
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_q       <= reduce_idx(vertex_index_i);
          corner_q[0] <= reduce_idx(corner_a_i);
          corner_q[1] <= reduce_idx(corner_b_i);
          corner_q[2] <= reduce_idx(corner_c_i);
          corner_q[3] <= reduce_idx(corner_d_i);
          cnt_q       <= cnt_in;
          coord_q     <= {coord_x_i, coord_y_i, coord_z_i};
          for (int k = 0; k < 3; k++) res_q[k] <= '0;
          status_q    <= 1'b0;
        end
      end
      S_PRD: begin
        if (step_q == 5'd1) pa_q <= pos_rdata;
        for (int k = 0; k < 3; k++) begin
          if (step_q == 5'd2) begin
            e1_q[k] <= sub33(pos_rdata[VEC_W-1-32*k -: 32], pa_q[VEC_W-1-32*k -: 32]);
          end
          if (step_q == 5'd3) begin
            e2_q[k] <= sub33(pos_rdata[VEC_W-1-32*k -: 32], pa_q[VEC_W-1-32*k -: 32]);
          end
        end
      end
      S_MUL: begin
        if (step_q < 5'd6) prod_q <= mul_p;
        // odd step holds the first term of a pair, even step closes the pair
        if (step_q != 5'd0) begin
          if (step_q[0]) begin
            first_q <= prod_q;
          end else begin
            cross_q[2'(step_q[2:1] - 2'd1)] <= {first_q[65], first_q} - {prod_q[65], prod_q};
          end
        end
      end
      S_ABS: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= cross_q[k][66];
          mag_q[k] <= cross_q[k][66] ? 66'(~cross_q[k] + 67'd1) : cross_q[k][65:0];
        end
      end
      S_NORM: begin
        if (or_w == '0) begin
          status_q <= 1'b1;
        end else if ((or_w >> (7'd66 - nsh)) == '0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << nsh;
        end
      end
      S_SQR: begin
        if (step_q < 5'd3) prod_q <= mul_p;
        sq_s_q <= (step_q == 5'd0) ? '0 : sq_s_q + prod_q[62:0];
        if (step_q == 5'd3) begin
          sq_r_q   <= '0;
          sq_bit_q <= 63'(1) << 62;
        end
      end
      S_SQRT: begin
        if (sq_bit_q != '0) begin
          if (sq_s_q >= sq_t) begin
            sq_s_q <= sq_s_q - sq_t;
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end else begin
          // add half the length for rounding; the high part starts the remainder
          for (int k = 0; k < 3; k++) begin
            logic [46:0] num;
            num        = 47'({mag_q[k][65:36], 16'h0000}) + 47'(len_w[30:1]);
            rem_q[k]   <= 32'(num[46:17]);
            numlo_q[k] <= num[16:0];
            quo_q[k]   <= '0;
          end
        end
      end
      S_DIV: begin
        for (int k = 0; k < 3; k++) begin
          logic [31:0] r2;
          r2 = {rem_q[k][30:0], numlo_q[k][16]};
          if (r2 >= {1'b0, len_w}) begin
            rem_q[k] <= r2 - {1'b0, len_w};
            quo_q[k] <= {quo_q[k][15:0], 1'b1};
          end else begin
            rem_q[k] <= r2;
            quo_q[k] <= {quo_q[k][15:0], 1'b0};
          end
          numlo_q[k] <= {numlo_q[k][15:0], 1'b0};
        end
      end
      S_RES: begin
        for (int k = 0; k < 3; k++) begin
          res_q[k] <= neg_q[k] ? -(32'(quo_q[k])) : 32'(quo_q[k]);
        end
      end
      S_RCAP: begin
        for (int k = 0; k < 3; k++) res_q[k] <= nrm_rdata[VEC_W-1-32*k -: 32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_x_q      <= res_q[0];
      out_y_q      <= res_q[1];
      out_z_q      <= res_q[2];
      out_status_q <= status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_normal_x_o = out_x_q;
  assign out_normal_y_o = out_y_q;
  assign out_normal_z_o = out_z_q;
  assign status_o       = out_status_q;

endmodule

[rtl/mvna_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mvna_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mvna_checker.sv]
// Port-level checker for the mesh vertex normal accumulator, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mvna_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_normal_x_o,
  input logic [31:0] out_normal_y_o,
  input logic [31:0] out_normal_z_o,
  input logic        status_o
);

  // a degenerate face reports a zero normal
  `ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, out_valid_o && status_o,
               out_normal_x_o == '0 && out_normal_y_o == '0 && out_normal_z_o == '0)

  // one word in flight: stall right after a word is taken
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(out_normal_x_o) && $stable(status_o))

endmodule

bind mesh_vertex_normal_accumulator_core mvna_checker u_mvna_checker (.*);

[tb/mvna_checker.sv]
// Checker for the mesh vertex normal accumulator: watches both channels,
// predicts each result from its own store copies and compares. Depends on mvna_pkg.
`timescale 1ns / 1ps
module mvna_tb_checker
  import mvna_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         operation_i,
  input  logic [9:0]         vertex_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [2:0]         corner_count_i,
  input  logic [9:0]         corner_a_i,
  input  logic [9:0]         corner_b_i,
  input  logic [9:0]         corner_c_i,
  input  logic [9:0]         corner_d_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_normal_x_i,
  input  logic signed [31:0] out_normal_y_i,
  input  logic signed [31:0] out_normal_z_i,
  input  logic               status_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic               degen;
  } normal_t;

  logic signed [31:0] pos_x [1024];
  logic signed [31:0] pos_y [1024];
  logic signed [31:0] pos_z [1024];
  logic signed [31:0] acc_x [1024];
  logic signed [31:0] acc_y [1024];
  logic signed [31:0] acc_z [1024];
  normal_t expected_normals [$];

  assign pending_o = expected_normals.size();

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] s, logic signed [31:0] v);
    logic signed [33:0] t;
    t = 34'(s) + 34'(v);
    if (t > 34'sd2147483647) return 32'sh7fffffff;
    if (t < -34'sd2147483648) return 32'sh80000000;
    return t[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= s) r = b;
    end
    return r;
  endfunction

  function automatic normal_t face_normal(logic [9:0] ia, logic [9:0] ib, logic [9:0] ic);
    logic signed [32:0] e1 [3];
    logic signed [32:0] e2 [3];
    logic signed [67:0] cr [3];
    logic [67:0] mag [3];
    logic [63:0] sc [3];
    logic [63:0] ssum;
    logic [63:0] len;
    logic [63:0] q;
    int nbits;
    normal_t r;
    e1[0] = 33'(pos_x[ib]) - 33'(pos_x[ia]);
    e1[1] = 33'(pos_y[ib]) - 33'(pos_y[ia]);
    e1[2] = 33'(pos_z[ib]) - 33'(pos_z[ia]);
    e2[0] = 33'(pos_x[ic]) - 33'(pos_x[ia]);
    e2[1] = 33'(pos_y[ic]) - 33'(pos_y[ia]);
    e2[2] = 33'(pos_z[ic]) - 33'(pos_z[ia]);
    nbits = 0;
    for (int k = 0; k < 3; k++) begin
      cr[k] = 68'(e1[(k+1)%3]) * 68'(e2[(k+2)%3]) - 68'(e1[(k+2)%3]) * 68'(e2[(k+1)%3]);
      mag[k] = cr[k] < 0 ? 68'(-cr[k]) : 68'(cr[k]);
      for (int b = 0; b < 68; b++) if (mag[k][b] && b + 1 > nbits) nbits = b + 1;
    end
    r = '0;
    if (nbits == 0) begin
      r.degen = 1'b1;
      return r;
    end
    ssum = 0;
    for (int k = 0; k < 3; k++) begin
      sc[k] = nbits > 30 ? 64'(mag[k] >> (nbits - 30)) : 64'(mag[k] << (30 - nbits));
      ssum += sc[k] * sc[k];
    end
    len = int_sqrt(ssum);
    for (int k = 0; k < 3; k++) begin
      q = ((sc[k] << 16) + (len >> 1)) / len;
      if (k == 0) r.nx = cr[k] < 0 ? -32'(q) : 32'(q);
      if (k == 1) r.ny = cr[k] < 0 ? -32'(q) : 32'(q);
      if (k == 2) r.nz = cr[k] < 0 ? -32'(q) : 32'(q);
    end
    return r;
  endfunction

  task automatic apply_word();
    normal_t r;
    logic [9:0] corners [4];
    int cnt;
    r = '0;
    case (op_e'(operation_i))
      OP_WRITE_POS: begin
        pos_x[vertex_index_i] = coord_x_i;
        pos_y[vertex_index_i] = coord_y_i;
        pos_z[vertex_index_i] = coord_z_i;
      end
      OP_READ_NORMAL: begin
        r.nx = acc_x[vertex_index_i];
        r.ny = acc_y[vertex_index_i];
        r.nz = acc_z[vertex_index_i];
      end
      OP_ADD_FACE: begin
        corners = '{corner_a_i, corner_b_i, corner_c_i, corner_d_i};
        cnt = corner_count_i < 3 ? 3 : (corner_count_i > CORNER_LIMIT ? CORNER_LIMIT
              : corner_count_i);
        r = face_normal(corner_a_i, corner_b_i, corner_c_i);
        if (!r.degen) begin
          for (int k = 0; k < cnt; k++) begin
            acc_x[corners[k]] = sat_sum(acc_x[corners[k]], r.nx);
            acc_y[corners[k]] = sat_sum(acc_y[corners[k]], r.ny);
            acc_z[corners[k]] = sat_sum(acc_z[corners[k]], r.nz);
          end
        end
      end
      default: ;
    endcase
    expected_normals.insert(expected_normals.size(), r);
  endtask

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < 1024; i++) begin
      acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
    end
  end

  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected word x=%h y=%h z=%h st=%b", $time,
                   out_normal_x_i, out_normal_y_i, out_normal_z_i, status_i);
          fail_count_o++;
        end else begin
          e = expected_normals.pop_front();
          if (e.nx !== out_normal_x_i || e.ny !== out_normal_y_i ||
              e.nz !== out_normal_z_i || e.degen !== status_i) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h st=%b actual x=%h y=%h z=%h st=%b",
                     $time, e.nx, e.ny, e.nz, e.degen, out_normal_x_i, out_normal_y_i,
                     out_normal_z_i, status_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_word();
    end
  end

endmodule

[tb/tb.sv]
// Stimulus top for the mesh vertex normal accumulator: drives words, random
// gaps and stalls, gives the verdict. Depends on mvna_pkg, the core and mvna_tb_checker.
`timescale 1ns / 1ps
module tb
  import mvna_pkg::*;
();

  localparam int IdleLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = '0;
  logic [9:0]         vertex_index_i = '0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic [2:0]         corner_count_i = 3'd3;
  logic [9:0]         corner_a_i = '0;
  logic [9:0]         corner_b_i = '0;
  logic [9:0]         corner_c_i = '0;
  logic [9:0]         corner_d_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] out_normal_x_o;
  logic signed [31:0] out_normal_y_o;
  logic signed [31:0] out_normal_z_o;
  logic               status_o;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 calm = 1'b0;
  bit                 written [1024];

  always #4 clk_i = ~clk_i;

  mesh_vertex_normal_accumulator_core uut (.*);

  mvna_tb_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .vertex_index_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .corner_count_i, .corner_a_i, .corner_b_i,
    .corner_c_i, .corner_d_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_normal_x_i(out_normal_x_o), .out_normal_y_i(out_normal_y_o),
    .out_normal_z_i(out_normal_z_o), .status_i(status_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // Receiver stalls in random bursts.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** mesh_vertex_normal_accumulator_core: FAILED **");
      $finish;
    end
  end

  task automatic send_word(op_e op, logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [2:0] cnt, logic [9:0] a, logic [9:0] b,
                           logic [9:0] c, logic [9:0] d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    vertex_index_i <= idx;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    corner_count_i <= cnt;
    corner_a_i <= a;
    corner_b_i <= b;
    corner_c_i <= c;
    corner_d_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_WRITE_POS) written[idx] = 1'b1;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  // Corner indices: always from the vertices 0 to 63 that have positions.
  function automatic logic [9:0] pick_written();
    logic [9:0] v;
    do v = 10'($urandom_range(0, 63)); while (!written[v]);
    return v;
  endfunction

  task automatic send_face(logic [2:0] cnt);
    logic [9:0] a, b, c;
    a = pick_written();
    b = pick_written();
    c = pick_written();
    send_word(OP_ADD_FACE, 10'($urandom()), $urandom(), $urandom(), $urandom(), cnt, a, b,
              c, 10'($urandom()));
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, unit triangle, degenerate, odd counts.
    send_word(OP_WRITE_POS, 0, 0, 0, 0, 3, 0, 0, 0, 0);
    send_word(OP_WRITE_POS, 1, 32'h10000, 0, 0, 3, 0, 0, 0, 0);
    send_word(OP_WRITE_POS, 2, 0, 32'h10000, 0, 3, 0, 0, 0, 0);
    send_word(OP_WRITE_POS, 3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 3, 0, 0, 0, 0);
    send_word(OP_WRITE_POS, 4, 32'h80000000, 32'h7fffffff, 32'h80000000, 3, 0, 0, 0, 0);
    send_word(OP_WRITE_POS, 1023, 32'hffffffff, 32'h12345678, 32'h80000001, 3, 0, 0, 0, 0);
    send_word(OP_ADD_FACE, 0, 0, 0, 0, 3, 0, 1, 2, 0);
    send_word(OP_ADD_FACE, 0, 0, 0, 0, 4, 0, 1, 2, 1023);
    send_word(OP_ADD_FACE, 0, 0, 0, 0, 0, 2, 1, 0, 5);
    send_word(OP_ADD_FACE, 0, 0, 0, 0, 7, 3, 4, 1023, 1023);
    send_word(OP_ADD_FACE, 0, 0, 0, 0, 3, 1, 1, 2, 0);
    send_word(OP_ADD_FACE, 0, 0, 0, 0, 4, 3, 4, 3, 3);
    send_word(OP_NONE, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 7, 1023, 1023, 1023,
              1023);
    for (int i = 0; i < 6; i++) send_word(OP_ADD_FACE, 0, 0, 0, 0, 4, 0, 1, 2, 0);
    send_word(OP_READ_NORMAL, 0, 0, 0, 0, 3, 0, 0, 0, 0);
    send_word(OP_READ_NORMAL, 3, 0, 0, 0, 3, 0, 0, 0, 0);
    send_word(OP_READ_NORMAL, 1023, 0, 0, 0, 3, 0, 0, 0, 0);
    send_word(OP_READ_NORMAL, 700, 0, 0, 0, 3, 0, 0, 0, 0);
    // Accumulate on one vertex: the same face many times in the same direction.
    send_word(OP_WRITE_POS, 10, 0, 0, 0, 3, 0, 0, 0, 0);
    send_word(OP_WRITE_POS, 11, 32'h10000, 0, 0, 3, 0, 0, 0, 0);
    send_word(OP_WRITE_POS, 12, 0, 32'h10000, 0, 3, 0, 0, 0, 0);
    for (int i = 0; i < 70; i++) send_word(OP_ADD_FACE, 0, 0, 0, 0, 4, 10, 11, 12, 10);
    send_word(OP_READ_NORMAL, 10, 0, 0, 0, 3, 0, 0, 0, 0);
    for (int i = 0; i < 64; i++)
      send_word(OP_WRITE_POS, 10'(i), rand_coord(), rand_coord(), rand_coord(), 3, 0, 0, 0,
                0);
    // Random: mostly faces over the written region, with writes, reads and noise.
    n = 0;
    while (n < 1140) begin
      if (n > 1000) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: send_word(OP_WRITE_POS,
                        10'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom()),
                        rand_coord(), rand_coord(), rand_coord(), 3'($urandom()),
                        10'($urandom()), 10'($urandom()), 10'($urandom()), 10'($urandom()));
        2, 3: send_word(OP_READ_NORMAL, 10'($urandom()), $urandom(), $urandom(), $urandom(),
                        3'($urandom()), 10'($urandom()), 10'($urandom()), 10'($urandom()),
                        10'($urandom()));
        4: send_word(OP_NONE, 10'($urandom()), $urandom(), $urandom(), $urandom(),
                     3'($urandom()), 10'($urandom()), 10'($urandom()), 10'($urandom()),
                     10'($urandom()));
        default: send_face(3'($urandom()));
      endcase
      n++;
    end
    in_valid_i <= 1'b0;
    calm = 1'b1;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("** mesh_vertex_normal_accumulator_core: PASSED **");
    else
      $display("** mesh_vertex_normal_accumulator_core: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/mvna_pkg.sv
rtl/mvna_ram.sv
rtl/mesh_vertex_normal_accumulator_core.sv
rtl/mvna_checker.sv
tb/mvna_checker.sv
tb/tb.sv
